// File: hdl/tws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_pkg: shared types and constants
// codes, timing set and tick result of the three-wire serial master
// ----------------------------------------------------------------------------
package tws_pkg;

  localparam int unsigned TIMER_BITS_DEF = 8;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned BYTE_BITS      = 8;
  localparam int unsigned BIT_CNT_BITS   = 4;
  localparam int unsigned IN_TDATA_BITS  = 16;
  localparam int unsigned OUT_TDATA_BITS = 16;

  // line actions
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_START = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_END   = 3'd5
  } action_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SETUP  = 3'd0,
    REG_HIGH   = 3'd1,
    REG_SAMPLE = 3'd2,
    REG_RESET  = 3'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RST   = 3'd1,
    PH_SETUP = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LOW   = 3'd4,
    PH_RWAIT = 3'd5,
    PH_RHIGH = 3'd6
  } phase_e;

  localparam logic [BYTE_BITS-1:0] SETUP_RST  = 8'd22;
  localparam logic [BYTE_BITS-1:0] HIGH_RST   = 8'd4;
  localparam logic [BYTE_BITS-1:0] SAMPLE_RST = 8'd3;
  localparam logic [BYTE_BITS-1:0] RESET_RST  = 8'd20;

  typedef struct packed {
    logic [BYTE_BITS-1:0] setup_ticks;
    logic [BYTE_BITS-1:0] high_ticks;
    logic [BYTE_BITS-1:0] sample_ticks;
    logic [BYTE_BITS-1:0] reset_ticks;
  } timing_t;

  typedef struct packed {
    logic                 rejected;
    logic                 read_done;
    logic [BYTE_BITS-1:0] read_data;
    logic                 busy_res;
    logic                 line_drive;
    logic                 line_out;
    logic                 serial_clock;
    logic                 chip_enable;
  } result_t;

endpackage

// File: hdl/tws_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_cfg_regs: timing register file
// four 8-bit tick counts, written through the configuration channel
// ----------------------------------------------------------------------------
module tws_cfg_regs
  import tws_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [CFG_IDX_BITS-1:0] wr_index_i,
  input  logic [BYTE_BITS-1:0]    wr_data_i,
  output timing_t                 timing_o
);

  timing_t timing_q, timing_d;

  always_comb begin
    timing_d = timing_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_SETUP:  timing_d.setup_ticks  = wr_data_i;
        REG_HIGH:   timing_d.high_ticks   = wr_data_i;
        REG_SAMPLE: timing_d.sample_ticks = wr_data_i;
        REG_RESET:  timing_d.reset_ticks  = wr_data_i;
        default:    timing_d = timing_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timing_q <= '{setup_ticks: SETUP_RST, high_ticks: HIGH_RST,
                    sample_ticks: SAMPLE_RST, reset_ticks: RESET_RST};
    end else begin
      timing_q <= timing_d;
    end
  end

  assign timing_o = timing_q;

endmodule

// File: hdl/tws_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tws_engine: link sequencer
// advances the line state by one tick per step and forms the tick result
// ----------------------------------------------------------------------------
module tws_engine
  import tws_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [2:0]           action_i,
  input  logic [BYTE_BITS-1:0] data_byte_i,
  input  logic                 line_in_i,
  input  timing_t              timing_i,
  output result_t              result_o
);

  typedef logic [TIMER_BITS-1:0] tmr_t;

  function automatic tmr_t load_timer(input logic [BYTE_BITS-1:0] v);
    tmr_t t;
    t = TIMER_BITS'(v);
    if (t == '0) begin
      t = tmr_t'(1);
    end
    return t;
  endfunction

  phase_e                  phase_q, phase_d;
  logic [BIT_CNT_BITS-1:0] bitcnt_q, bitcnt_d;
  tmr_t                    wait_q, wait_d;
  logic [BYTE_BITS-1:0]    shift_q, shift_d;
  logic [BYTE_BITS-1:0]    hold_q, hold_d;
  logic                    ce_q, ce_d, clk_q, clk_d, out_q, out_d, drv_q, drv_d;
  logic                    rejected, done, expired;
  logic [BIT_CNT_BITS-1:0] bitcnt_inc;

  assign expired    = (wait_q == tmr_t'(1));
  assign bitcnt_inc = bitcnt_q + BIT_CNT_BITS'(1);

  always_comb begin
    phase_d  = phase_q;
    bitcnt_d = bitcnt_q;
    wait_d   = wait_q;
    shift_d  = shift_q;
    hold_d   = hold_q;
    ce_d     = ce_q;
    clk_d    = clk_q;
    out_d    = out_q;
    drv_d    = drv_q;
    rejected = 1'b0;
    done     = 1'b0;
    if (phase_q != PH_IDLE) begin
      rejected = (action_i >= ACT_RESET) && (action_i <= ACT_END);
      unique case (phase_q)
        PH_RST: begin
          wait_d = wait_q - tmr_t'(1);
          if (expired) phase_d = PH_IDLE;
        end
        PH_SETUP: begin
          wait_d = wait_q - tmr_t'(1);
          if (expired) begin
            clk_d   = 1'b1;
            wait_d  = load_timer(timing_i.high_ticks);
            phase_d = PH_HIGH;
          end
        end
        PH_LOW: begin
          clk_d   = 1'b1;
          wait_d  = load_timer(timing_i.high_ticks);
          phase_d = PH_HIGH;
        end
        PH_HIGH: begin
          wait_d = wait_q - tmr_t'(1);
          if (expired) begin
            clk_d    = 1'b0;
            bitcnt_d = bitcnt_inc;
            if (bitcnt_inc[BIT_CNT_BITS-1]) begin
              phase_d = PH_IDLE;
            end else begin
              out_d   = shift_q[bitcnt_inc[2:0]];
              phase_d = PH_LOW;
            end
          end
        end
        PH_RWAIT: begin
          wait_d = wait_q - tmr_t'(1);
          if (expired) begin
            shift_d[bitcnt_q[2:0]] = line_in_i;
            clk_d   = 1'b1;
            wait_d  = load_timer(timing_i.high_ticks);
            phase_d = PH_RHIGH;
          end
        end
        PH_RHIGH: begin
          wait_d = wait_q - tmr_t'(1);
          if (expired) begin
            clk_d    = 1'b0;
            bitcnt_d = bitcnt_inc;
            if (bitcnt_inc[BIT_CNT_BITS-1]) begin
              hold_d  = shift_q;
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              wait_d  = load_timer(timing_i.sample_ticks);
              phase_d = PH_RWAIT;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else begin
      unique case (action_i)
        ACT_RESET: begin
          ce_d    = 1'b0;
          clk_d   = 1'b0;
          out_d   = 1'b0;
          drv_d   = 1'b1;
          wait_d  = load_timer(timing_i.reset_ticks);
          phase_d = PH_RST;
        end
        ACT_START: begin
          shift_d  = data_byte_i;
          bitcnt_d = '0;
          out_d    = data_byte_i[0];
          drv_d    = 1'b1;
          clk_d    = 1'b0;
          ce_d     = 1'b1;
          wait_d   = load_timer(timing_i.setup_ticks);
          phase_d  = PH_SETUP;
        end
        ACT_WRITE: begin
          shift_d  = data_byte_i;
          bitcnt_d = '0;
          out_d    = data_byte_i[0];
          drv_d    = 1'b1;
          clk_d    = 1'b0;
          phase_d  = PH_LOW;
        end
        ACT_READ: begin
          bitcnt_d = '0;
          out_d    = 1'b1;
          drv_d    = 1'b0;
          clk_d    = 1'b0;
          wait_d   = load_timer(timing_i.sample_ticks);
          phase_d  = PH_RWAIT;
        end
        ACT_END: begin
          ce_d  = 1'b0;
          clk_d = 1'b0;
        end
        default: ;  // no action, unused codes too
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      bitcnt_q <= '0;
      wait_q   <= '0;
      shift_q  <= '0;
      hold_q   <= '0;
      ce_q     <= 1'b0;
      clk_q    <= 1'b0;
      out_q    <= 1'b0;
      drv_q    <= 1'b1;
    end else if (step_i) begin
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      wait_q   <= wait_d;
      shift_q  <= shift_d;
      hold_q   <= hold_d;
      ce_q     <= ce_d;
      clk_q    <= clk_d;
      out_q    <= out_d;
      drv_q    <= drv_d;
    end
  end

  // result shows the levels after this tick
  assign result_o = '{rejected: rejected, read_done: done, read_data: hold_d,
                      busy_res: (phase_d != PH_IDLE), line_drive: drv_d,
                      line_out: out_d, serial_clock: clk_d, chip_enable: ce_d};

endmodule

// File: hdl/three_wire_serial_master_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_serial_master_unit: three-wire serial link master
// chip enable, serial clock and bidirectional data driven one tick per item
// ----------------------------------------------------------------------------
//
// channel   direction  contents
// s_axis    in         one link tick: action, data byte, sampled data line
// m_axis    out        line levels and status after that tick
// cfg       in         timing register write: index and 8-bit value
//
// one tick per clock cycle while m_axis does not stall; a tick's result reaches m_axis
// through the input register, then the result register
// the tick rate is set by the sequencer step in tws_engine
// rst_ni clears the timing registers to their defaults and the link to idle
// a stalled m_axis holds its result and the input register; s_axis stalls
// only when both registers are full
//
module three_wire_serial_master_unit
  import tws_pkg::*;
#(
  parameter int unsigned TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // action[2:0], data_byte[10:3], line_in[11], zeros[15:12]
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // chip_enable[0], serial_clock[1], line_out[2], line_drive[3], busy_res[4],
  // read_data[12:5], read_done[13], rejected[14], zero[15]
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [BYTE_BITS-1:0]      cfg_data_i
);

  // input register
  logic                 in_valid_q;
  logic [2:0]           in_action_q;
  logic [BYTE_BITS-1:0] in_data_q;
  logic                 in_line_q;

  // result register
  logic    out_valid_q;
  result_t out_q;
  result_t step_result;
  timing_t timing;

  logic advance;   // result register can take a new tick
  logic step;      // the tick in the input register runs this cycle
  logic in_take;   // input transaction

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // configuration is always taken; the user writes only while the link is idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  tws_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .timing_o   (timing)
  );

  tws_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .action_i    (in_action_q),
    .data_byte_i (in_data_q),
    .line_in_i   (in_line_q),
    .timing_i    (timing),
    .result_o    (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tdata[2:0];
      in_data_q   <= s_axis_tdata[10:3];
      in_line_q   <= s_axis_tdata[11];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= step_result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q};

`ifndef SYNTH
  // input side stalls only with both registers holding a tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // a completed read leaves the link idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.read_done) |-> !out_q.busy_res)
    else $error("read done while still busy");

  // a released data line is always left pulled high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.line_drive) |-> out_q.line_out)
    else $error("data line released low");

  // a tick waiting in the input register runs as soon as the output frees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && m_axis_tready) |=> out_valid_q)
    else $error("tick lost between registers");
`endif

endmodule

// File: dv/three_wire_serial_master_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_wire_serial_master_unit_tb: self-checking bench for the serial master
// drives link ticks with start/write/read/end transfers, busy-time actions and
// noise across several timing settings; every tick result is predicted by a
// cycle model of the sequencer and compared field by field in arrival order
// ----------------------------------------------------------------------------
module three_wire_serial_master_unit_tb;
  import tws_pkg::*;

  // action codes the block treats as no action
  localparam logic [2:0] ACT_SPARE_A = 3'd6;
  localparam logic [2:0] ACT_SPARE_B = 3'd7;
  // index outside the register map, written once to see it ignored
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  localparam int unsigned NUM_SETTINGS = 10;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // tick predictor and result store
  // --------------------------------------------------------------------------
  class tick_scoreboard;
    logic [BYTE_BITS-1:0]    setup_t, high_t, sample_t, reset_t;
    phase_e                  phase;
    logic [BIT_CNT_BITS-1:0] bit_cnt;
    int unsigned             timer;
    logic [BYTE_BITS-1:0]    shreg, read_hold;
    logic                    ce, sclk, dout, drv;
    result_t                 line_q[$];
    int unsigned             errors, checked, reads, rejects;

    function new();
      setup_t   = SETUP_RST;
      high_t    = HIGH_RST;
      sample_t  = SAMPLE_RST;
      reset_t   = RESET_RST;
      phase     = PH_IDLE;
      bit_cnt   = '0;
      timer     = 0;
      shreg     = '0;
      read_hold = '0;
      ce        = 1'b0;
      sclk      = 1'b0;
      dout      = 1'b0;
      drv       = 1'b1;
      errors    = 0;
      checked   = 0;
      reads     = 0;
      rejects   = 0;
    endfunction

    // a zero register value still waits one tick
    function int unsigned ticks_of(logic [BYTE_BITS-1:0] v);
      return (v == '0) ? 1 : int'(v);
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    function int unsigned pending();
      return line_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [BYTE_BITS-1:0] v);
      case (idx)
        REG_SETUP:  setup_t  = v;
        REG_HIGH:   high_t   = v;
        REG_SAMPLE: sample_t = v;
        REG_RESET:  reset_t  = v;
        default: ;
      endcase
    endfunction

    // one accepted tick: advance the sequencer and queue the line levels
    function void note_tick(logic [2:0] act, logic [BYTE_BITS-1:0] d, logic ln);
      result_t r;
      logic    rej, done;
      rej  = 1'b0;
      done = 1'b0;
      if (phase != PH_IDLE) begin
        if (act >= ACT_RESET && act <= ACT_END) rej = 1'b1;
        case (phase)
          PH_RST: begin
            timer--;
            if (timer == 0) phase = PH_IDLE;
          end
          PH_SETUP: begin
            timer--;
            if (timer == 0) begin
              sclk  = 1'b1;
              timer = ticks_of(high_t);
              phase = PH_HIGH;
            end
          end
          PH_LOW: begin
            sclk  = 1'b1;
            timer = ticks_of(high_t);
            phase = PH_HIGH;
          end
          PH_HIGH: begin
            timer--;
            if (timer == 0) begin
              sclk = 1'b0;
              bit_cnt++;
              if (bit_cnt >= 8) begin
                phase = PH_IDLE;
              end else begin
                dout  = shreg[bit_cnt[2:0]];
                phase = PH_LOW;
              end
            end
          end
          PH_RWAIT: begin
            timer--;
            if (timer == 0) begin
              shreg[bit_cnt[2:0]] = ln;
              sclk  = 1'b1;
              timer = ticks_of(high_t);
              phase = PH_RHIGH;
            end
          end
          PH_RHIGH: begin
            timer--;
            if (timer == 0) begin
              sclk = 1'b0;
              bit_cnt++;
              if (bit_cnt >= 8) begin
                read_hold = shreg;
                done      = 1'b1;
                phase     = PH_IDLE;
              end else begin
                timer = ticks_of(sample_t);
                phase = PH_RWAIT;
              end
            end
          end
          default: phase = PH_IDLE;
        endcase
      end else begin
        case (act)
          ACT_RESET: begin
            {ce, sclk, dout, drv} = 4'b0001;
            timer = ticks_of(reset_t);
            phase = PH_RST;
          end
          ACT_START: begin
            shreg   = d;
            bit_cnt = '0;
            dout    = d[0];
            drv     = 1'b1;
            sclk    = 1'b0;
            ce      = 1'b1;
            timer   = ticks_of(setup_t);
            phase   = PH_SETUP;
          end
          ACT_WRITE: begin
            shreg   = d;
            bit_cnt = '0;
            dout    = d[0];
            drv     = 1'b1;
            sclk    = 1'b0;
            phase   = PH_LOW;
          end
          ACT_READ: begin
            bit_cnt = '0;
            dout    = 1'b1;
            drv     = 1'b0;
            sclk    = 1'b0;
            timer   = ticks_of(sample_t);
            phase   = PH_RWAIT;
          end
          ACT_END: begin
            ce   = 1'b0;
            sclk = 1'b0;
          end
          default: ;
        endcase
      end
      r.chip_enable  = ce;
      r.serial_clock = sclk;
      r.line_out     = dout;
      r.line_drive   = drv;
      r.busy_res     = (phase != PH_IDLE);
      r.read_data    = read_hold;
      r.read_done    = done;
      r.rejected     = rej;
      reads   += done;
      rejects += rej;
      line_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_BITS-1:0] raw);
      result_t exp, got;
      logic    bad;
      got = result_t'(raw[$bits(result_t)-1:0]);
      if (line_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result %h at %0t", raw, $realtime);
        return;
      end
      exp = line_q.pop_front();
      checked++;
      bad = (got.chip_enable  !== exp.chip_enable)  ||
            (got.serial_clock !== exp.serial_clock) ||
            (got.line_out     !== exp.line_out)     ||
            (got.line_drive   !== exp.line_drive)   ||
            (got.busy_res     !== exp.busy_res)     ||
            (got.read_data    !== exp.read_data)    ||
            (got.read_done    !== exp.read_done)    ||
            (got.rejected     !== exp.rejected)     ||
            (raw[OUT_TDATA_BITS-1:$bits(result_t)] !== '0);
      if (bad) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch on result %0d at %0t", checked, $realtime);
          $display("  exp ce=%0b clk=%0b out=%0b drv=%0b busy=%0b data=%02h done=%0b rej=%0b",
                   exp.chip_enable, exp.serial_clock, exp.line_out, exp.line_drive,
                   exp.busy_res, exp.read_data, exp.read_done, exp.rejected);
          $display("  got ce=%0b clk=%0b out=%0b drv=%0b busy=%0b data=%02h done=%0b rej=%0b",
                   got.chip_enable, got.serial_clock, got.line_out, got.line_drive,
                   got.busy_res, got.read_data, got.read_done, got.rejected);
          if (raw[OUT_TDATA_BITS-1:$bits(result_t)] !== '0)
            $display("  nonzero pad bits %0b", raw[OUT_TDATA_BITS-1:$bits(result_t)]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block hookup
  // --------------------------------------------------------------------------
  logic                      clk_i;
  logic                      rst_ni;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]   cfg_index_i;
  logic [BYTE_BITS-1:0]      cfg_data_i;

  three_wire_serial_master_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  tick_scoreboard sb = new();

  // stimulus controls shared between the driving processes
  bit          gaps_on;      // random idling on both sides
  bit          noise_on;     // stray actions while the link is busy
  bit          line_fixed;   // hold the sampled data line at line_level
  logic        line_level;
  int unsigned hold_asked, hold_served;
  int unsigned ticks_sent, actions_sent, cfg_writes;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // result side: random backpressure plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asked) begin
        // long stall counted here so the input side backs up
        hold_served   = hold_asked;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready = !(gaps_on && $urandom_range(0, 99) < 35);
      end
    end
  end

  // every result transaction goes to the checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog: ends the run when no transaction of any kind happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no transaction for %0d cycles at %0t", STALL_LIMIT, $realtime);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // tick driver
  // --------------------------------------------------------------------------
  // one link tick; called at a falling edge and returns at a falling edge
  task automatic send_tick(input logic [2:0] act, input logic [BYTE_BITS-1:0] d);
    logic ln;
    ln = line_fixed ? line_level : 1'($urandom_range(0, 1));
    if (gaps_on && $urandom_range(0, 99) < 35) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    s_axis_tdata  = {{(IN_TDATA_BITS-12){1'b0}}, ln, d, act};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    // only actions taken by an idle link count as link actions
    if (!sb.busy() && act >= ACT_RESET && act <= ACT_END) actions_sent++;
    sb.note_tick(act, d, ln);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // keep ticking until the link is idle, with occasional stray actions
  task automatic settle();
    while (sb.busy()) begin
      if (noise_on && $urandom_range(0, 99) < 6)
        send_tick(3'($urandom_range(0, 7)), 8'($urandom));
      else
        send_tick(ACT_NONE, 8'($urandom));
    end
  endtask

  task automatic do_action(input logic [2:0] act, input logic [BYTE_BITS-1:0] d);
    send_tick(act, d);
    settle();
  endtask

  // well-formed transfer: optional reset, command byte, one to three data bytes either way, end
  task automatic random_transfer();
    int unsigned n;
    n = $urandom_range(1, 3);
    if ($urandom_range(0, 9) == 0) do_action(ACT_RESET, 8'($urandom));
    do_action(ACT_START, 8'($urandom));
    repeat (n) begin
      if ($urandom_range(0, 1)) do_action(ACT_WRITE, 8'($urandom));
      else                      do_action(ACT_READ, 8'($urandom));
      repeat ($urandom_range(0, 2)) send_tick(ACT_NONE, 8'($urandom));
    end
    do_action(ACT_END, 8'($urandom));
  endtask

  // timing register write; the caller first waits until the link is idle and all results are back
  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [BYTE_BITS-1:0] v);
    cfg_index_i = idx;
    cfg_data_i  = v;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, v);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned p);
    logic [BYTE_BITS-1:0] su, hi, sa, rs;
    case (p)
      1: {su, hi, sa, rs} = {8'd1, 8'd1, 8'd1, 8'd1};
      2: {su, hi, sa, rs} = '0;                   // zero still waits a tick
      8: {su, hi, sa, rs} = {8'hFF, 8'd1, 8'd1, 8'hFF};
      default: begin
        su = 8'($urandom_range(1, 6));
        hi = 8'($urandom_range(1, 4));
        sa = 8'($urandom_range(1, 4));
        rs = 8'($urandom_range(1, 6));
      end
    endcase
    settle();
    s_axis_tvalid = 1'b0;
    // sender pauses until every expected result has come back
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_write(REG_SETUP, su);
    cfg_write(REG_HIGH, hi);
    cfg_write(REG_SAMPLE, sa);
    cfg_write(REG_RESET, rs);
    if (p == NUM_SETTINGS - 1) cfg_write(REG_UNUSED, 8'($urandom));
    cfg_valid_i = 1'b0;
  endtask

  // every action and the busy-time rejection, all timings at one tick
  task automatic directed_ticks();
    noise_on = 1'b0;
    send_tick(ACT_NONE, 8'h00);
    send_tick(ACT_SPARE_A, 8'hFF);
    send_tick(ACT_SPARE_B, 8'h00);
    do_action(ACT_END, 8'h00);
    do_action(ACT_RESET, 8'hFF);
    do_action(ACT_START, 8'h00);
    do_action(ACT_WRITE, 8'hFF);
    line_fixed = 1'b1;
    line_level = 1'b1;
    do_action(ACT_READ, 8'h00);
    line_level = 1'b0;
    do_action(ACT_READ, 8'hFF);
    line_fixed = 1'b0;
    do_action(ACT_READ, 8'h3C);
    do_action(ACT_END, 8'h00);
    // write without chip enable
    do_action(ACT_WRITE, 8'h5A);
    // each action while a start is still running
    send_tick(ACT_START, 8'hA5);
    send_tick(ACT_RESET, 8'h00);
    send_tick(ACT_START, 8'hFF);
    send_tick(ACT_WRITE, 8'h0F);
    send_tick(ACT_READ, 8'hF0);
    send_tick(ACT_END, 8'h00);
    send_tick(ACT_SPARE_B, 8'h00);
    settle();
    do_action(ACT_END, 8'hFF);
    noise_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned budget [NUM_SETTINGS];
    int unsigned target, roll;
    // tick budget per timing setting
    budget        = '{200, 200, 120, 180, 100, 100, 100, 100, 250, 120};
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_SETUP;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    noise_on      = 1'b1;
    line_fixed    = 1'b0;
    line_level    = 1'b0;
    hold_asked    = 0;
    hold_served   = 0;
    ticks_sent    = 0;
    actions_sent  = 0;
    cfg_writes    = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int unsigned p = 0; p < NUM_SETTINGS; p++) begin
      // the first setting runs on the reset defaults
      if (p > 0) apply_setting(p);
      // one whole setting with no idling on either side
      gaps_on = (p != 3);
      target  = ticks_sent + budget[p];
      // long receiver hold-off while the first ticks keep coming
      if (p == 0) hold_asked = 1;
      if (p == 1) directed_ticks();
      while (ticks_sent < target) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          random_transfer();
        end else if (roll < 90) begin
          // stray action of any code, possibly out of order
          do_action(3'($urandom_range(0, 7)), 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) send_tick(ACT_NONE, 8'($urandom));
        end
      end
    end

    settle();
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // keep waiting so a stray extra result would still show up
    repeat (10) @(negedge clk_i);

    $display("covered %0d ticks with %0d link actions under %0d timing settings (%0d cfg writes)",
             ticks_sent, actions_sent, NUM_SETTINGS, cfg_writes);
    $display("%0d reads completed, %0d busy-time actions rejected, %0d results checked, %0d bad",
             sb.reads, sb.rejects, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
